>>> sv/lptl_pkg.sv
// Shared types, constants and helpers for the longest-prefix table lookup.
package lptl_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int NAME_CHARS  = 5;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int NAME_W      = 8 * NAME_CHARS;
   localparam int MLEN_W      = $clog2(NAME_CHARS + 1);

   // Fixed field widths of the ports
   localparam int ENTRY_INDEX_W = 6;
   localparam int NAME_PORT_W   = 40;
   localparam int RADIUS_W      = 16;
   localparam int ENTRY_COUNT_W = 7;
   localparam int MATCH_LEN_W   = 3;

   // Table word: name in the top bits, radius below
   localparam int ENTRY_W = NAME_W + RADIUS_W;

   // Item queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } st_type;

   // One classified word as it sits in the queue
   typedef struct packed {
      op_type                   op;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [NAME_W-1:0]        name;
      logic [RADIUS_W-1:0]      radius;
      logic [NAME_CHARS-1:0]    live;   // bit k: chars 0..k of the name are all non-NUL
   } q_item_type;

   // Byte k of a name, k = 0 is the first character
   function automatic logic [7:0] name_byte(input logic [NAME_W-1:0] v, input int k);
      name_byte = v[NAME_W-1-8*k -: 8];
   endfunction

   // Prefix mask of non-NUL characters
   function automatic logic [NAME_CHARS-1:0] live_mask(input logic [NAME_W-1:0] v);
      logic run;
      logic [NAME_CHARS-1:0] m;
      run = 1'b1;
      m   = '0;
      for (int k = 0; k < NAME_CHARS; k++) begin
         run  = run & (name_byte(v, k) != 8'h00);
         m[k] = run;
      end
      live_mask = m;
   endfunction

   // Leading characters where the query is live and both names agree
   function automatic logic [MLEN_W-1:0] match_len(input logic [NAME_W-1:0]     q,
                                                   input logic [NAME_CHARS-1:0] qlive,
                                                   input logic [NAME_W-1:0]     e);
      logic run;
      logic [MLEN_W-1:0] n;
      run = 1'b1;
      n   = '0;
      for (int k = 0; k < NAME_CHARS; k++) begin
         run = run & qlive[k] & (name_byte(q, k) == name_byte(e, k));
         if (run) begin
            n = n + MLEN_W'(1);
         end
      end
      match_len = n;
   endfunction

endpackage

>>> sv/lptl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lptl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lptl_front.sv
// Front end: takes request words, classifies them and queues them for the back end.
module lptl_front
   import lptl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic [NAME_PORT_W-1:0]   req_name_chars,
   input  logic [RADIUS_W-1:0]      req_radius_in,
   output q_item_type               q_item,
   input  logic                     q_pop,
   output logic                     q_valid
);

   q_item_type        q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;
   q_item_type        new_item;

   // Classify the incoming word
   always_comb begin
      new_item.op          = op_type'(req_op);
      new_item.entry_index = req_entry_index;
      new_item.name        = NAME_W'(req_name_chars);
      new_item.radius      = req_radius_in;
      new_item.live        = live_mask(NAME_W'(req_name_chars));
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop & q_valid;
   assign q_item    = q_mem_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> sv/lptl_back.sv
// Back end: performs table writes and walks the table for queries.
module lptl_back
   import lptl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  q_item_type               q_item,
   input  logic                     q_valid,
   output logic                     q_pop,
   input  logic [ENTRY_COUNT_W-1:0] entry_count,
   output logic                     ram_wr_en,
   output logic [IDX_W-1:0]         ram_wr_addr,
   output logic [ENTRY_W-1:0]       ram_wr_data,
   output logic                     ram_rd_en,
   output logic [IDX_W-1:0]         ram_rd_addr,
   input  logic [ENTRY_W-1:0]       ram_rd_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic [RADIUS_W-1:0]      rsp_radius_out,
   output logic [ENTRY_INDEX_W-1:0] rsp_best_index,
   output logic [MATCH_LEN_W-1:0]   rsp_match_length
);

   st_type                  state_ff, state_in;
   logic [CNT_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]        limit_ff, limit_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [NAME_W-1:0]       q_name_ff, q_name_in;
   logic [NAME_CHARS-1:0]   q_live_ff, q_live_in;
   logic [MLEN_W-1:0]       best_len_ff, best_len_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [RADIUS_W-1:0]     best_rad_ff, best_rad_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [RADIUS_W-1:0]     rsp_radius_ff, rsp_radius_in;
   logic [ENTRY_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [MATCH_LEN_W-1:0]  rsp_mlen_ff, rsp_mlen_in;

   logic                    start_query;
   logic                    issue;
   logic                    rsp_load;
   logic [MLEN_W-1:0]       cur_len;
   logic [CNT_W-1:0]        count_limit;

   // Entries actually searched: entry_count clipped to the table depth
   assign count_limit = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : CNT_W'(entry_count);
   assign issue   = (state_ff == ST_SCAN) && (rd_addr_ff < limit_ff);
   assign cur_len = match_len(q_name_ff, q_live_ff, ram_rd_data[ENTRY_W-1 -: NAME_W]);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_item.op == OP_QUERY) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!issue && !cmp_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      q_pop       = 1'b0;
      start_query = 1'b0;
      ram_wr_en   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == OP_QUERY) begin
                  start_query = 1'b1;
               end else begin
                  ram_wr_en = (32'(q_item.entry_index) < 32'(TABLE_DEPTH));
               end
            end
         end
         ST_SCAN: begin
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   // Table port
   assign ram_wr_addr = IDX_W'(q_item.entry_index);
   assign ram_wr_data = {q_item.name, q_item.radius};
   assign ram_rd_en   = issue;
   assign ram_rd_addr = IDX_W'(rd_addr_ff);

   // Scan datapath: read one entry a cycle, compare the entry read last cycle
   always_comb begin
      rd_addr_in  = rd_addr_ff;
      limit_in    = limit_ff;
      q_name_in   = q_name_ff;
      q_live_in   = q_live_ff;
      best_len_in = best_len_ff;
      best_idx_in = best_idx_ff;
      best_rad_in = best_rad_ff;
      cmp_vld_in  = issue;
      cmp_idx_in  = IDX_W'(rd_addr_ff);
      if (start_query) begin
         rd_addr_in  = '0;
         limit_in    = count_limit;
         q_name_in   = q_item.name;
         q_live_in   = q_item.live;
         best_len_in = '0;
         best_idx_in = '0;
         best_rad_in = '0;
      end else begin
         if (issue) begin
            rd_addr_in = rd_addr_ff + CNT_W'(1);
         end
         // strictly longer match wins, so the earliest entry keeps a tie
         if (cmp_vld_ff && cur_len > best_len_ff) begin
            best_len_in = cur_len;
            best_idx_in = cmp_idx_ff;
            best_rad_in = ram_rd_data[RADIUS_W-1:0];
         end
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_radius_in = rsp_radius_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_mlen_in   = rsp_mlen_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = (best_len_ff != '0);
         rsp_radius_in = best_rad_ff;
         rsp_index_in  = ENTRY_INDEX_W'(best_idx_ff);
         rsp_mlen_in   = MATCH_LEN_W'(best_len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      limit_ff      <= limit_in;
      cmp_idx_ff    <= cmp_idx_in;
      q_name_ff     <= q_name_in;
      q_live_ff     <= q_live_in;
      best_len_ff   <= best_len_in;
      best_idx_ff   <= best_idx_in;
      best_rad_ff   <= best_rad_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_radius_ff <= rsp_radius_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_mlen_ff   <= rsp_mlen_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_radius_out   = rsp_radius_ff;
   assign rsp_best_index   = rsp_index_ff;
   assign rsp_match_length = rsp_mlen_ff;

endmodule

>>> sv/longest_prefix_table_lookup.sv
// Top level of the longest-prefix name table lookup.
// A request word either writes one table slot (op 0: name and radius stored at
// entry_index, no response) or queries by name (op 1: exactly one response word
// with the entry whose leading characters match longest, earliest slot on a
// tie; found is 0 with zero fields if nothing matches one character).
// Words enter a two-deep queue, so up to two can be taken while the back end
// is busy. The back end serves one word at a time: a write is stored as it
// leaves the queue, a query walks the table through a single RAM read port
// at one entry per cycle, and the back end stays busy with a query until its
// response word is loaded into the output register, which waits while the
// previous response is still stalled. The user must write entry_count
// through the csr port only while no word is in flight; the block itself
// does not enforce this. csr_ready is always high. Slots that were never
// written hold unknown data and should not lie within entry_count.
module longest_prefix_table_lookup
   import lptl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic [NAME_PORT_W-1:0]   req_name_chars,
   input  logic [RADIUS_W-1:0]      req_radius_in,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic [RADIUS_W-1:0]      rsp_radius_out,
   output logic [ENTRY_INDEX_W-1:0] rsp_best_index,
   output logic [MATCH_LEN_W-1:0]   rsp_match_length,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ENTRY_COUNT_W-1:0] csr_entry_count
);

   logic [ENTRY_COUNT_W-1:0] entry_count_ff, entry_count_in;
   q_item_type               q_item;
   logic                     q_valid;
   logic                     q_pop;
   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [ENTRY_W-1:0]       ram_wr_data;
   logic                     ram_rd_en;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [ENTRY_W-1:0]       ram_rd_data;

   // Configuration register
   assign csr_ready      = 1'b1;
   assign entry_count_in = (csr_valid && csr_ready) ? csr_entry_count : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   lptl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_name_chars  (req_name_chars),
      .req_radius_in   (req_radius_in),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .q_valid         (q_valid)
   );

   lptl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_item           (q_item),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .entry_count      (entry_count_ff),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_radius_out   (rsp_radius_out),
      .rsp_best_index   (rsp_best_index),
      .rsp_match_length (rsp_match_length)
   );

   // Name and radius table
   lptl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> sv/lptl_checker.sv
// Port-level checks for the longest-prefix table lookup, bound to the top level.
module lptl_checker
   import lptl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_found,
   input  logic [RADIUS_W-1:0]      rsp_radius_out,
   input  logic [ENTRY_INDEX_W-1:0] rsp_best_index,
   input  logic [MATCH_LEN_W-1:0]   rsp_match_length
);

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_radius_out) && $stable(rsp_best_index)
         && $stable(rsp_match_length))
      else $error("response word changed while stalled");

   // A miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_radius_out == '0 && rsp_best_index == '0
         && rsp_match_length == '0)
      else $error("miss response with nonzero fields");

   // A hit matched between one and NAME_CHARS characters
   a_hit_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_match_length != '0
         && 32'(rsp_match_length) <= 32'(NAME_CHARS))
      else $error("hit response with bad match length");

   // No response right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind longest_prefix_table_lookup lptl_checker u_lptl_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for the longest-prefix table lookup.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lptl_pkg::*;

   // Run limits
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
   localparam int PHASE_WORDS   = 58;

   // One expected response word
   typedef struct packed {
      logic                     found;
      logic [RADIUS_W-1:0]      radius;
      logic [ENTRY_INDEX_W-1:0] index;
      logic [MATCH_LEN_W-1:0]   mlen;
   } lookup_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_op = 1'b0;
   logic [ENTRY_INDEX_W-1:0] req_entry_index = '0;
   logic [NAME_PORT_W-1:0]   req_name_chars = '0;
   logic [RADIUS_W-1:0]      req_radius_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_found;
   logic [RADIUS_W-1:0]      rsp_radius_out;
   logic [ENTRY_INDEX_W-1:0] rsp_best_index;
   logic [MATCH_LEN_W-1:0]   rsp_match_length;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [ENTRY_COUNT_W-1:0] csr_entry_count = '0;

   // Shadow of the table and the search count
   logic [NAME_PORT_W-1:0] slot_name    [TABLE_DEPTH];
   logic [RADIUS_W-1:0]    slot_radius  [TABLE_DEPTH];
   bit                     slot_written [TABLE_DEPTH];
   int                     search_count = 0;

   lookup_result_type pending_lookups [$];

   int burst_left = 0;
   int stall_left = 0;
   int n_fail     = 0;
   int n_writes   = 0;
   int n_queries  = 0;
   int n_hits     = 0;
   int n_settings = 0;

   longest_prefix_table_lookup u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_entry_index  (req_entry_index),
      .req_name_chars   (req_name_chars),
      .req_radius_in    (req_radius_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_radius_out   (rsp_radius_out),
      .rsp_best_index   (rsp_best_index),
      .rsp_match_length (rsp_match_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_entry_count  (csr_entry_count)
   );

   always #1 clock = ~clock;

   // Character k of a name, k = 0 in the top byte
   function automatic logic [7:0] char_at(input logic [NAME_PORT_W-1:0] v, input int k);
      return v[8 * (NAME_CHARS - 1 - k) +: 8];
   endfunction

   // Characters before the first NUL
   function automatic int name_len(input logic [NAME_PORT_W-1:0] v);
      int k;
      k = 0;
      while (k < NAME_CHARS && char_at(v, k) != 8'h00) k++;
      return k;
   endfunction

   // Longest common prefix over the searched slots, earliest slot wins a tie
   function automatic lookup_result_type search_table(input logic [NAME_PORT_W-1:0] q);
      lookup_result_type r;
      int n, qlen, lim, j;
      r    = '0;
      n    = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : search_count;
      qlen = name_len(q);
      for (int i = 0; i < n; i++) begin
         lim = name_len(slot_name[i]);
         if (qlen < lim) lim = qlen;
         j = 0;
         while (j < lim && char_at(q, j) == char_at(slot_name[i], j)) j++;
         if (j > int'(r.mlen)) begin
            r.found  = 1'b1;
            r.mlen   = MATCH_LEN_W'(j);
            r.index  = ENTRY_INDEX_W'(i);
            r.radius = slot_radius[i];
         end
      end
      return r;
   endfunction

   // Mostly a short name over a small alphabet, optional junk after the NUL; sometimes random bits
   function automatic logic [NAME_PORT_W-1:0] make_name();
      logic [NAME_PORT_W-1:0] v;
      int  len;
      bit  junk;
      if ($urandom_range(0, 6) == 0) return NAME_PORT_W'({$urandom, $urandom});
      v    = '0;
      len  = $urandom_range(0, NAME_CHARS);
      junk = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < NAME_CHARS; k++) begin
         if (k < len)
            v[8 * (NAME_CHARS - 1 - k) +: 8] = 8'h61 + 8'($urandom_range(0, 3));
         else if (k > len && junk)
            v[8 * (NAME_CHARS - 1 - k) +: 8] = 8'($urandom);
      end
      return v;
   endfunction

   // Keep a random prefix of a stored name, rewrite the tail
   function automatic logic [NAME_PORT_W-1:0] near_name(input logic [NAME_PORT_W-1:0] base);
      logic [NAME_PORT_W-1:0] v;
      int cut;
      v   = base;
      cut = $urandom_range(0, NAME_CHARS);
      for (int k = cut; k < NAME_CHARS; k++)
         v[8 * (NAME_CHARS - 1 - k) +: 8] =
            ($urandom_range(0, 2) == 0) ? 8'h00 : 8'h61 + 8'($urandom_range(0, 3));
      return v;
   endfunction

   // Send one request word in bursts with random gaps
   task automatic send_word(input op_type op, input logic [ENTRY_INDEX_W-1:0] idx,
                            input logic [NAME_PORT_W-1:0] name,
                            input logic [RADIUS_W-1:0] radius);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_entry_index <= idx;
      req_name_chars  <= name;
      req_radius_in   <= radius;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (op == OP_WRITE) begin
         slot_name[idx]    = name;
         slot_radius[idx]  = radius;
         slot_written[idx] = 1'b1;
         n_writes++;
      end else begin
         pending_lookups.push_back(search_table(name));
         n_queries++;
      end
   endtask

   // Stop sending and wait for every pending response, optionally let trailing writes finish
   task automatic drain_results(input bit settle);
      @(negedge clock) req_valid <= 1'b0;
      burst_left = 0;
      while (pending_lookups.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write entry_count while the block is idle
   task automatic set_entry_count(input int value);
      drain_results(1'b1);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_entry_count <= ENTRY_COUNT_W'(value);
      do @(posedge clock); while (!csr_ready);
      search_count = value;
      n_settings++;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Reset count is zero: a query searches nothing
   task automatic test_reset_count();
      send_word(OP_QUERY, '0, {"abc", 16'h0}, '0);
      send_word(OP_QUERY, '1, 40'hFF_FFFF_FFFF, '1);
   endtask

   // Hand-built entries: ties, empty names, junk after NUL, full-length names
   task automatic test_prefix_rules();
      send_word(OP_WRITE, 6'd0,  {"ab", 24'h0},          16'h0000);
      send_word(OP_WRITE, 6'd1,  {"abc", 16'h0},         16'h1234);
      send_word(OP_WRITE, 6'd2,  {"abd", 16'h0},         16'hFFFF);
      send_word(OP_WRITE, 6'd3,  {"b", 32'h0},           16'h0800);
      send_word(OP_WRITE, 6'd4,  {8'h00, "ABCD"},        16'h5555);
      send_word(OP_WRITE, 6'd5,  "abcde",                16'hAAAA);
      send_word(OP_WRITE, 6'd6,  {"ab", 8'h00, "zz"},    16'h0001);
      send_word(OP_WRITE, 6'd7,  40'hFF_FFFF_FFFF,       16'h7FFF);
      send_word(OP_WRITE, 6'd63, {"q", 32'h0},           16'hFFFF);
      set_entry_count(8);
      send_word(OP_QUERY, '0, "abcde",             '0);
      send_word(OP_QUERY, '0, {"abcd", 8'h0},      '0);
      send_word(OP_QUERY, '0, {"abx", 16'h0},      '0);
      send_word(OP_QUERY, '0, 40'h0,               '0);
      send_word(OP_QUERY, '0, {8'h00, "abcd"},     '0);
      send_word(OP_QUERY, '0, {"zzz", 16'h0},      '0);
      send_word(OP_QUERY, '0, 40'hFF_FFFF_FFFF,    '0);
      send_word(OP_QUERY, '0, {"ab", 8'h00, "cc"}, '0);
      send_word(OP_QUERY, '0, {"b", 32'h0},        '0);
      send_word(OP_QUERY, '0, {"a", 32'h0},        '0);
      set_entry_count(1);
      send_word(OP_QUERY, '0, {"abc", 16'h0},      '0);
      set_entry_count(0);
      send_word(OP_QUERY, '0, {"abc", 16'h0},      '0);
   endtask

   // Populate every slot so that any count is legal
   task automatic test_fill_table();
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (!slot_written[i])
            send_word(OP_WRITE, ENTRY_INDEX_W'(i), make_name(), RADIUS_W'($urandom));
   endtask

   // Random traffic over several counts, extremes and overlarge ones included
   task automatic test_count_settings();
      int setting [9];
      int lim;
      setting = '{64, 1, 127, 65, 0, 0, 0, 0, 0};
      setting[4] = $urandom_range(2, 63);
      setting[5] = $urandom_range(2, 63);
      setting[6] = $urandom_range(66, 126);
      setting[7] = $urandom_range(2, 63);
      foreach (setting[p]) begin
         set_entry_count(setting[p]);
         lim = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : search_count;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // hold the sender until every pending response has come back
            if (i == PHASE_WORDS / 2) drain_results(1'b0);
            if ($urandom_range(0, 9) < 3)
               send_word(OP_WRITE, ENTRY_INDEX_W'($urandom), make_name(),
                         RADIUS_W'($urandom));
            else if (lim > 0 && $urandom_range(0, 1) == 0)
               send_word(OP_QUERY, ENTRY_INDEX_W'($urandom),
                         near_name(slot_name[$urandom_range(0, lim - 1)]),
                         RADIUS_W'($urandom));
            else
               send_word(OP_QUERY, ENTRY_INDEX_W'($urandom), make_name(),
                         RADIUS_W'($urandom));
         end
      end
   endtask

   // Response stall: short stalls, short runs, occasional long free stretches
   always @(negedge clock) begin
      if (stall_left == 0) begin
         if (rsp_stall) begin
            rsp_stall <= 1'b0;
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 8);
         end
      end else begin
         stall_left--;
      end
   end

   // Compare each response word with the oldest pending lookup
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            if (n_fail < 10)
               $display("unexpected response: found=%0d radius=%h index=%0d len=%0d",
                        rsp_found, rsp_radius_out, rsp_best_index, rsp_match_length);
            n_fail++;
         end else begin
            if (rsp_found        !== pending_lookups[0].found  ||
                rsp_radius_out   !== pending_lookups[0].radius ||
                rsp_best_index   !== pending_lookups[0].index  ||
                rsp_match_length !== pending_lookups[0].mlen) begin
               if (n_fail < 10)
                  $display("mismatch: exp found=%0d radius=%h index=%0d len=%0d, %s%0d %h %0d %0d",
                           pending_lookups[0].found, pending_lookups[0].radius,
                           pending_lookups[0].index, pending_lookups[0].mlen, "got ",
                           rsp_found, rsp_radius_out, rsp_best_index, rsp_match_length);
               n_fail++;
            end
            if (pending_lookups[0].found) n_hits++;
            void'(pending_lookups.pop_front());
         end
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d responses pending",
               CYCLE_LIMIT, pending_lookups.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_reset_count();
      test_prefix_rules();
      test_fill_table();
      test_count_settings();
      drain_results(1'b1);
      $display("ran %0d table writes and %0d lookups (%0d hits) over %0d count settings",
               n_writes, n_queries, n_hits, n_settings);
      $display("response mismatches: %0d", n_fail);
      if (n_fail == 0 && pending_lookups.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
